// File: rtl/rhp_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
`timescale 1ns / 1ps

package rhp_pkg;

    localparam int PIX_W   = 8;
    localparam int OUT_W   = 16;
    localparam int DEN_W   = 11;  // 6*delta <= 1530
    localparam int QBITS   = 16;  // quotient bits per divider
    localparam int STAGES  = QBITS + 1;

    typedef struct packed {
        logic              gray;
        logic [OUT_W-1:0]  val;
        logic [DEN_W-1:0]  hue_den;
        logic [DEN_W-1:0]  hue_rem;
        logic [QBITS-1:0]  hue_q;
        logic [PIX_W-1:0]  sat_div;
        logic [PIX_W-1:0]  sat_rem;
        logic [QBITS-1:0]  sat_low;
        logic [QBITS-1:0]  sat_q;
    } t_stage;

endpackage

// File: rtl/rhp_div_step.sv
// One restoring-division step for both the hue and the saturation dividers.
`timescale 1ns / 1ps

module rhp_div_step (
    input  rhp_pkg::t_stage i_stage,
    output rhp_pkg::t_stage o_stage
);
    import rhp_pkg::*;

    logic [DEN_W:0] hue_shift;
    logic [PIX_W:0] sat_shift;
    logic           hue_ge;
    logic           sat_ge;

    always_comb begin
        hue_shift = {i_stage.hue_rem, 1'b0};
        sat_shift = {i_stage.sat_rem, i_stage.sat_low[QBITS-1]};
        hue_ge    = hue_shift >= {1'b0, i_stage.hue_den};
        sat_ge    = sat_shift >= {1'b0, i_stage.sat_div};

        o_stage         = i_stage;
        o_stage.hue_rem = hue_ge ? DEN_W'(hue_shift - {1'b0, i_stage.hue_den})
                                 : hue_shift[DEN_W-1:0];
        o_stage.hue_q   = {i_stage.hue_q[QBITS-2:0], hue_ge};
        o_stage.sat_rem = sat_ge ? PIX_W'(sat_shift - {1'b0, i_stage.sat_div})
                                 : sat_shift[PIX_W-1:0];
        o_stage.sat_low = {i_stage.sat_low[QBITS-2:0], 1'b0};
        o_stage.sat_q   = {i_stage.sat_q[QBITS-2:0], sat_ge};
    end

endmodule

// File: rtl/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter.
`timescale 1ns / 1ps
//
// Converts a stream of 8-bit RGB pixels into 16-bit HSV fractions.
// Input channel: i_valid / o_stall with i_red, i_green, i_blue.
// Output channel: o_valid / i_stall with o_hue, o_saturation, o_brightness.
// A transaction moves on a clock edge with valid high and stall low.
// One stage finds max, min, delta, sector and the hue numerator, then
// 16 stages each produce one quotient bit of both the hue and the
// saturation divisions (restoring, one step instance per stage serves both).
// Throughput is one pixel per cycle while o_stall is low. Each stage
// holds while the stage after it is full and stalled, so empty slots
// close up and input keeps being taken while a result waits; o_stall
// rises only when every stage is full and the receiver stalls.
// Synchronous active-low reset empties the pipeline; no pixel is lost
// or repeated under stall.
//
module rgb_to_hsv_pixel (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [rhp_pkg::PIX_W-1:0]  i_red,
    input  logic [rhp_pkg::PIX_W-1:0]  i_green,
    input  logic [rhp_pkg::PIX_W-1:0]  i_blue,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rhp_pkg::OUT_W-1:0]  o_hue,
    output logic [rhp_pkg::OUT_W-1:0]  o_saturation,
    output logic [rhp_pkg::OUT_W-1:0]  o_brightness
);
    import rhp_pkg::*;

    t_stage             r_pipe  [STAGES];
    logic [STAGES-1:0]  r_valid;
    t_stage             w_step  [STAGES-1];
    logic [STAGES-1:0]  w_en;
    t_stage             n_first;

    logic [PIX_W-1:0]   mx;
    logic [PIX_W-1:0]   mn;
    logic [PIX_W-1:0]   dlt;
    logic signed [11:0] num;
    logic [23:0]        sat_num;

    // stage enable: a stage moves when empty or when its successor moves
    always_comb begin
        w_en[STAGES-1] = !r_valid[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];

    always_comb begin
        mx  = (i_red > i_green) ? i_red : i_green;
        mx  = (mx > i_blue) ? mx : i_blue;
        mn  = (i_red < i_green) ? i_red : i_green;
        mn  = (mn < i_blue) ? mn : i_blue;
        dlt = mx - mn;

        priority if (i_red == mx) begin
            num = 12'(signed'({4'd0, i_green})) - 12'(signed'({4'd0, i_blue}));
        end else if (i_green == mx) begin
            num = 12'(signed'({3'd0, dlt, 1'b0})) + 12'(signed'({4'd0, i_blue}))
                - 12'(signed'({4'd0, i_red}));
        end else begin
            num = 12'(signed'({2'd0, dlt, 2'b0})) + 12'(signed'({4'd0, i_red}))
                - 12'(signed'({4'd0, i_green}));
        end

        n_first.hue_den = DEN_W'(6 * {3'd0, dlt});
        if (num < 0) begin
            num = num + 12'(signed'({1'b0, n_first.hue_den}));
        end

        sat_num          = {dlt, 16'd0} - {16'd0, dlt};
        n_first.gray     = (dlt == '0);
        n_first.val      = {mx, mx};
        n_first.hue_rem  = num[DEN_W-1:0];
        n_first.hue_q    = '0;
        n_first.sat_div  = mx;
        n_first.sat_rem  = sat_num[23:16];
        n_first.sat_low  = sat_num[15:0];
        n_first.sat_q    = '0;
    end

    genvar g;
    generate
        for (g = 0; g < STAGES - 1; g++) begin : g_div
            rhp_div_step u_step (
                .i_stage (r_pipe[g]),
                .o_stage (w_step[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r_pipe[0] <= n_first;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (w_en[k] && r_valid[k-1]) begin
                r_pipe[k] <= w_step[k-1];
            end
        end
    end

    assign o_valid      = r_valid[STAGES-1];
    assign o_hue        = r_pipe[STAGES-1].gray ? '0 : r_pipe[STAGES-1].hue_q;
    assign o_saturation = r_pipe[STAGES-1].gray ? '0 : r_pipe[STAGES-1].sat_q;
    assign o_brightness = r_pipe[STAGES-1].val;

endmodule

// File: rtl/rhp_checker.sv
// Port-level assertions for the RGB to HSV pixel converter, with bind.
`timescale 1ns / 1ps

module rhp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [rhp_pkg::OUT_W-1:0]  o_hue,
    input logic [rhp_pkg::OUT_W-1:0]  o_saturation,
    input logic [rhp_pkg::OUT_W-1:0]  o_brightness
);
    import rhp_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hue) && $stable(o_saturation))
        else $error("stalled transaction changed");

    a_val_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_brightness[15:8] == o_brightness[7:0])
        else $error("brightness is not max*257");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturation == '0 |-> o_hue == '0)
        else $error("hue set on gray pixel");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_brightness == '0 |-> o_saturation == '0)
        else $error("saturation set on black pixel");

endmodule

bind rgb_to_hsv_pixel rhp_checker u_rhp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_hue        (o_hue),
    .o_saturation (o_saturation),
    .o_brightness (o_brightness)
);
